@@ rtl/vector3_alu_assert.svh @@
// Assertion macros for the vector ALU checker.
`ifndef VECTOR3_ALU_ASSERT_SVH
`define VECTOR3_ALU_ASSERT_SVH

// Check that holds outside reset.
`define V3A_CHK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("vector3_alu port check failed");

// Check that also covers the reset cycles.
`define V3A_CHK_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("vector3_alu reset check failed");

`endif

@@ rtl/v3a_pkg.sv @@
`default_nettype none
package v3a_pkg;

  localparam int FRAC_BITS = 16;
  localparam int NUM_LANES = 3;
  localparam int LANE_LAT  = 3;
  localparam int MRG_LAT   = 2;
  localparam int SQRT_ITER = 32;
  localparam int SQRT_LAT  = SQRT_ITER + 1;
  localparam int QB        = 33;
  localparam int DIV_LAT   = QB + 1;
  localparam int PIPE_LAT  = LANE_LAT + MRG_LAT + SQRT_LAT + DIV_LAT + 1;

  typedef logic signed [31:0] q_t;
  typedef logic signed [63:0] prod_t;
  typedef logic signed [65:0] wide_t;
  typedef logic        [32:0] len_t;

  typedef enum logic [2:0] {
    FN_ADD     = 3'd0,
    FN_SUB     = 3'd1,
    FN_SCALE   = 3'd2,
    FN_DOT     = 3'd3,
    FN_CROSS   = 3'd4,
    FN_LENGTH  = 3'd5,
    FN_RESCALE = 3'd6
  } func_t;

  localparam q_t    Q_MAX     = 32'sh7FFF_FFFF;
  localparam q_t    Q_MIN     = 32'sh8000_0000;
  localparam wide_t Q_MAX_W   = 66'sd2147483647;
  localparam wide_t Q_MIN_W   = -66'sd2147483648;
  localparam wide_t RND_HALF  = wide_t'(1) <<< (FRAC_BITS - 1);
  localparam len_t  LIM_POS   = 33'h0_7FFF_FFFF;
  localparam len_t  LIM_NEG   = 33'h0_8000_0000;
  localparam len_t  Q_TOP     = 33'h1_0000_0000;

  typedef struct packed {
    logic [2:0] func;
    q_t a_x;
    q_t a_y;
    q_t a_z;
    q_t b_x;
    q_t b_y;
    q_t b_z;
    q_t k_scalar;
  } in_t;

  typedef struct packed {
    q_t   r_x;
    q_t   r_y;
    q_t   r_z;
    q_t   r_scalar;
    logic saturated;
    logic zero_length;
  } out_t;

  typedef struct packed {
    q_t   val;
    logic sat;
  } sat_t;

  typedef struct packed {
    logic [2:0] func;
    q_t         vec;
    logic       sat;
    prod_t      p1;
    prod_t      p2;
  } lane_t;

  typedef struct packed {
    logic [2:0]       func;
    q_t [2:0]         vec;
    logic             vsat;
    q_t               dot;
    logic             dsat;
    logic [2:0][63:0] n;
    logic [63:0]      sq;
  } mrg_t;

  typedef struct packed {
    logic [2:0] func;
    q_t [2:0]   vec;
    logic       vsat;
    q_t         dot;
    logic       dsat;
    len_t       len;
  } aln_t;

  function automatic sat_t clamp_w(wide_t v);
    sat_t r;
    r.val = v[31:0];
    r.sat = 1'b0;
    if (v > Q_MAX_W) begin
      r.val = Q_MAX;
      r.sat = 1'b1;
    end else if (v < Q_MIN_W) begin
      r.val = Q_MIN;
      r.sat = 1'b1;
    end
    return r;
  endfunction

  // Round to nearest, ties upward, dropping the extra fraction bits.
  function automatic wide_t round_w(wide_t v);
    return (v + RND_HALF) >>> FRAC_BITS;
  endfunction

endpackage
`default_nettype wire

@@ rtl/v3a_lane.sv @@
`default_nettype none
module v3a_lane (
  input  logic           clk,
  input  logic           en,
  input  logic [2:0]     func,
  input  v3a_pkg::q_t    a_i,
  input  v3a_pkg::q_t    a_j,
  input  v3a_pkg::q_t    a_k,
  input  v3a_pkg::q_t    b_i,
  input  v3a_pkg::q_t    b_j,
  input  v3a_pkg::q_t    b_k,
  input  v3a_pkg::q_t    k_scalar,
  output v3a_pkg::lane_t lane_o
);
  import v3a_pkg::*;

  logic [2:0]         func1_r, func2_r;
  q_t                 m1a_r, m1b_r, m2a_r, m2b_r;
  q_t                 m1a_nxt, m1b_nxt, m2a_nxt, m2b_nxt;
  logic signed [32:0] as1_r, as2_r, as_nxt;
  prod_t              p1_r, p2_r;
  sat_t               res;
  lane_t              lane_r, lane_nxt;

  // Pick multiplier operands for the operation.
  always_comb begin
    m1a_nxt = a_i;
    m1b_nxt = k_scalar;
    m2a_nxt = a_i;
    m2b_nxt = k_scalar;
    case (func)
      FN_DOT: begin
        m1b_nxt = b_i;
      end
      FN_CROSS: begin
        m1a_nxt = a_j;
        m1b_nxt = b_k;
        m2a_nxt = a_k;
        m2b_nxt = b_j;
      end
      FN_LENGTH, FN_RESCALE: begin
        m1b_nxt = a_i;
      end
      default: ;
    endcase
    if (func == FN_SUB) begin
      as_nxt = {a_i[31], a_i} - {b_i[31], b_i};
    end else begin
      as_nxt = {a_i[31], a_i} + {b_i[31], b_i};
    end
  end

  always_comb begin
    case (func2_r)
      FN_ADD, FN_SUB: res = clamp_w(wide_t'(as2_r));
      FN_SCALE:       res = clamp_w(round_w(wide_t'(p1_r)));
      FN_CROSS:       res = clamp_w(round_w(wide_t'(p1_r) - wide_t'(p2_r)));
      default:        res = '0;
    endcase
    lane_nxt.func = func2_r;
    lane_nxt.vec  = res.val;
    lane_nxt.sat  = res.sat;
    lane_nxt.p1   = p1_r;
    lane_nxt.p2   = p2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      func1_r <= func;
      m1a_r   <= m1a_nxt;
      m1b_r   <= m1b_nxt;
      m2a_r   <= m2a_nxt;
      m2b_r   <= m2b_nxt;
      as1_r   <= as_nxt;
      func2_r <= func1_r;
      p1_r    <= m1a_r * m1b_r;
      p2_r    <= m2a_r * m2b_r;
      as2_r   <= as1_r;
      lane_r  <= lane_nxt;
    end
  end

  assign lane_o = lane_r;

endmodule
`default_nettype wire

@@ rtl/v3a_merge.sv @@
`default_nettype none
module v3a_merge (
  input  logic           clk,
  input  logic           en,
  input  v3a_pkg::lane_t lane_i [3],
  output v3a_pkg::mrg_t  mrg_o
);
  import v3a_pkg::*;

  mrg_t  m1_r, m1_nxt, mrg_r, mrg_nxt;
  wide_t dsum_r, dsum_nxt;
  sat_t  dres;

  always_comb begin
    m1_nxt      = '0;
    m1_nxt.func = lane_i[0].func;
    for (int i = 0; i < NUM_LANES; i++) begin
      m1_nxt.vec[i] = lane_i[i].vec;
      m1_nxt.n[i]   = lane_i[i].p2;
    end
    m1_nxt.vsat = lane_i[0].sat | lane_i[1].sat | lane_i[2].sat;
    // Squares are never negative, so the plain bits add up the length sum.
    m1_nxt.sq   = lane_i[0].p1[63:0] + lane_i[1].p1[63:0] + lane_i[2].p1[63:0];
    dsum_nxt    = wide_t'(lane_i[0].p1) + wide_t'(lane_i[1].p1) + wide_t'(lane_i[2].p1);
  end

  always_comb begin
    dres    = clamp_w(round_w(dsum_r));
    mrg_nxt = m1_r;
    if (m1_r.func == FN_DOT) begin
      mrg_nxt.dot  = dres.val;
      mrg_nxt.dsat = dres.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r   <= m1_nxt;
      dsum_r <= dsum_nxt;
      mrg_r  <= mrg_nxt;
    end
  end

  assign mrg_o = mrg_r;

endmodule
`default_nettype wire

@@ rtl/v3a_sqrt.sv @@
`default_nettype none
module v3a_sqrt (
  input  logic          clk,
  input  logic          en,
  input  logic [63:0]   sq,
  output v3a_pkg::len_t len_o
);
  import v3a_pkg::*;

  logic [63:0] rem_r    [SQRT_ITER];
  logic [63:0] root_r   [SQRT_ITER];
  logic [63:0] rem_src  [SQRT_ITER];
  logic [63:0] root_src [SQRT_ITER];
  logic [63:0] rem_nxt  [SQRT_ITER];
  logic [63:0] root_nxt [SQRT_ITER];
  logic [63:0] trial    [SQRT_ITER];
  len_t        len_r, len_nxt;

  // One result bit per stage, from the top pair of bits down.
  always_comb begin
    rem_src[0]  = sq;
    root_src[0] = '0;
    for (int i = 1; i < SQRT_ITER; i++) begin
      rem_src[i]  = rem_r[i-1];
      root_src[i] = root_r[i-1];
    end
    for (int i = 0; i < SQRT_ITER; i++) begin
      trial[i] = root_src[i] + (64'd1 << (62 - 2 * i));
      if (rem_src[i] >= trial[i]) begin
        rem_nxt[i]  = rem_src[i] - trial[i];
        root_nxt[i] = (root_src[i] >> 1) + (64'd1 << (62 - 2 * i));
      end else begin
        rem_nxt[i]  = rem_src[i];
        root_nxt[i] = root_src[i] >> 1;
      end
    end
    // Round to nearest.
    len_nxt = len_t'(root_r[SQRT_ITER-1][31:0])
            + len_t'(rem_r[SQRT_ITER-1] > root_r[SQRT_ITER-1]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < SQRT_ITER; i++) begin
        rem_r[i]  <= rem_nxt[i];
        root_r[i] <= root_nxt[i];
      end
      len_r <= len_nxt;
    end
  end

  assign len_o = len_r;

endmodule
`default_nettype wire

@@ rtl/v3a_div.sv @@
`default_nettype none
module v3a_div (
  input  logic                   clk,
  input  logic                   en,
  input  v3a_pkg::prod_t         n,
  input  v3a_pkg::len_t          len,
  output logic [v3a_pkg::QB-1:0] q_o,
  output logic                   ovf_o,
  output logic                   neg_o
);
  import v3a_pkg::*;

  logic [64:0]   rem_r  [DIV_LAT];
  logic [33:0]   dv_r   [DIV_LAT];
  logic [QB-1:0] q_r    [DIV_LAT];
  logic          ovf_r  [DIV_LAT];
  logic          neg_r  [DIV_LAT];
  logic [64:0]   rem_nxt [DIV_LAT];
  logic [QB-1:0] q_nxt   [DIV_LAT];
  logic [66:0]   trial   [DIV_LAT];
  logic [63:0]   mag;
  logic [64:0]   num;
  logic [33:0]   dv0;

  // Numerator 2|n| + len over divisor 2 len rounds half away from zero.
  always_comb begin
    mag = n[63] ? 64'(-n) : 64'(n);
    num = {mag, 1'b0} + 65'(len);
    dv0 = {len, 1'b0};
    rem_nxt[0] = num;
    q_nxt[0]   = '0;
    trial[0]   = {dv0, 33'd0};
    for (int s = 1; s < DIV_LAT; s++) begin
      trial[s] = 67'(dv_r[s-1]) << (QB - s);
      if (67'(rem_r[s-1]) >= trial[s]) begin
        rem_nxt[s] = 65'(67'(rem_r[s-1]) - trial[s]);
        q_nxt[s]   = q_r[s-1] | (QB'(1) << (QB - s));
      end else begin
        rem_nxt[s] = rem_r[s-1];
        q_nxt[s]   = q_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= rem_nxt[0];
      q_r[0]   <= q_nxt[0];
      dv_r[0]  <= dv0;
      ovf_r[0] <= 67'(num) >= trial[0];
      neg_r[0] <= n[63];
      for (int s = 1; s < DIV_LAT; s++) begin
        rem_r[s] <= rem_nxt[s];
        q_r[s]   <= q_nxt[s];
        dv_r[s]  <= dv_r[s-1];
        ovf_r[s] <= ovf_r[s-1];
        neg_r[s] <= neg_r[s-1];
      end
    end
  end

  assign q_o   = q_r[DIV_LAT-1];
  assign ovf_o = ovf_r[DIV_LAT-1];
  assign neg_o = neg_r[DIV_LAT-1];

endmodule
`default_nettype wire

@@ rtl/vector3_alu.sv @@
// Three-component vector ALU, signed fixed point with FRAC_BITS fraction bits.
// Input channel: in_valid/in_ready carry one beat with an operation code,
// vectors a and b and a scalar k. Output channel: out_valid/out_ready carry
// one result beat per input beat, in order: vector r, scalar r_scalar and the
// saturated and zero_length flags.
// Throughput is one beat per cycle unless the receiver stalls. The path is:
// three lane stages with the multipliers, two merge stages that add the lane
// products, 33 stages of the digit-by-digit square root and 34 stages of the
// restoring divider in each lane, then the output register. Every operation
// walks the same path, so results never overtake one another.
// When the receiver stalls, the whole pipeline holds and in_ready drops in
// the same cycle; the output register keeps its beat until it is taken.
// Reset (synchronous, rst_n low) empties the pipeline: out_valid falls and
// any beats in flight are dropped. There is no clearing pass and no
// configuration.
`default_nettype none
module vector3_alu (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  v3a_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output v3a_pkg::out_t out_data
);
  import v3a_pkg::*;

  logic [PIPE_LAT-1:0] vld_r;
  logic                en;
  q_t                  av [NUM_LANES];
  q_t                  bv [NUM_LANES];
  lane_t               lanes [NUM_LANES];
  mrg_t                mrg;
  len_t                len;
  mrg_t                side1_r [SQRT_LAT];
  aln_t                side2_r [DIV_LAT];
  aln_t                aln_nxt;
  aln_t                tl;
  logic [QB-1:0]       qv  [NUM_LANES];
  logic                ovf [NUM_LANES];
  logic                neg [NUM_LANES];
  len_t                mag [NUM_LANES];
  q_t                  rv  [NUM_LANES];
  logic                rs  [NUM_LANES];
  out_t                out_r, out_nxt;

  // Advance everything together whenever the output register can move.
  assign en       = ~vld_r[PIPE_LAT-1] | out_ready;
  assign in_ready = en;

  assign av[0] = in_data.a_x;
  assign av[1] = in_data.a_y;
  assign av[2] = in_data.a_z;
  assign bv[0] = in_data.b_x;
  assign bv[1] = in_data.b_y;
  assign bv[2] = in_data.b_z;

  // One lane per component; cross products use the other two components.
  for (genvar gl = 0; gl < NUM_LANES; gl++) begin : g_lane
    v3a_lane u_lane (
      .clk      (clk),
      .en       (en),
      .func     (in_data.func),
      .a_i      (av[gl]),
      .a_j      (av[(gl + 1) % NUM_LANES]),
      .a_k      (av[(gl + 2) % NUM_LANES]),
      .b_i      (bv[gl]),
      .b_j      (bv[(gl + 1) % NUM_LANES]),
      .b_k      (bv[(gl + 2) % NUM_LANES]),
      .k_scalar (in_data.k_scalar),
      .lane_o   (lanes[gl])
    );
  end

  v3a_merge u_merge (
    .clk    (clk),
    .en     (en),
    .lane_i (lanes),
    .mrg_o  (mrg)
  );

  v3a_sqrt u_sqrt (
    .clk   (clk),
    .en    (en),
    .sq    (mrg.sq),
    .len_o (len)
  );

  // Side data rides alongside the square root, then alongside the dividers.
  always_comb begin
    aln_nxt.func = side1_r[SQRT_LAT-1].func;
    aln_nxt.vec  = side1_r[SQRT_LAT-1].vec;
    aln_nxt.vsat = side1_r[SQRT_LAT-1].vsat;
    aln_nxt.dot  = side1_r[SQRT_LAT-1].dot;
    aln_nxt.dsat = side1_r[SQRT_LAT-1].dsat;
    aln_nxt.len  = len;
  end

  for (genvar gd = 0; gd < NUM_LANES; gd++) begin : g_div
    v3a_div u_div (
      .clk   (clk),
      .en    (en),
      .n     (prod_t'(side1_r[SQRT_LAT-1].n[gd])),
      .len   (len),
      .q_o   (qv[gd]),
      .ovf_o (ovf[gd]),
      .neg_o (neg[gd])
    );
  end

  assign tl = side2_r[DIV_LAT-1];

  // Rescale: clamp the quotient magnitude, apply the sign, saturate.
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      mag[i] = (ovf[i] || (qv[i] > Q_TOP)) ? Q_TOP : qv[i];
      rs[i]  = 1'b0;
      if (neg[i]) begin
        if (mag[i] > LIM_NEG) begin
          rv[i] = Q_MIN;
          rs[i] = 1'b1;
        end else begin
          rv[i] = q_t'(33'd0 - mag[i]);
        end
      end else begin
        if (mag[i] > LIM_POS) begin
          rv[i] = Q_MAX;
          rs[i] = 1'b1;
        end else begin
          rv[i] = q_t'(mag[i][31:0]);
        end
      end
    end
  end

  always_comb begin
    out_nxt = '0;
    case (tl.func)
      FN_ADD, FN_SUB, FN_SCALE, FN_CROSS: begin
        out_nxt.r_x       = tl.vec[0];
        out_nxt.r_y       = tl.vec[1];
        out_nxt.r_z       = tl.vec[2];
        out_nxt.saturated = tl.vsat;
      end
      FN_DOT: begin
        out_nxt.r_scalar  = tl.dot;
        out_nxt.saturated = tl.dsat;
      end
      FN_LENGTH: begin
        if (tl.len > LIM_POS) begin
          out_nxt.r_scalar  = Q_MAX;
          out_nxt.saturated = 1'b1;
        end else begin
          out_nxt.r_scalar = q_t'(tl.len[31:0]);
        end
      end
      FN_RESCALE: begin
        if (tl.len == '0) begin
          out_nxt.zero_length = 1'b1;
        end else begin
          out_nxt.r_x       = rv[0];
          out_nxt.r_y       = rv[1];
          out_nxt.r_z       = rv[2];
          out_nxt.saturated = rs[0] | rs[1] | rs[2];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1_r[0] <= mrg;
      for (int i = 1; i < SQRT_LAT; i++) begin
        side1_r[i] <= side1_r[i-1];
      end
      side2_r[0] <= aln_nxt;
      for (int i = 1; i < DIV_LAT; i++) begin
        side2_r[i] <= side2_r[i-1];
      end
      out_r <= out_nxt;
    end
  end

  // Beat-valid flags shadow the payload stages; reset drops them all.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[PIPE_LAT-1];
  assign out_data  = out_r;

endmodule
`default_nettype wire

@@ rtl/v3a_chk.sv @@
`default_nettype none
`include "vector3_alu_assert.svh"
module v3a_chk (
  input logic          clk,
  input logic          rst_n,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input v3a_pkg::out_t out_data
);

  logic zl_rest;

  // Any field beside the zero_length flag that is set.
  assign zl_rest = |{out_data.r_x, out_data.r_y, out_data.r_z, out_data.r_scalar,
                     out_data.saturated};

  // Hold a stalled result beat.
  `V3A_CHK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data))
  // An empty output stage never blocks the input.
  `V3A_CHK(a_ready_free, !out_valid |-> in_ready)
  // Zero-length rescale clears every field.
  `V3A_CHK(a_zl_clear, out_valid && out_data.zero_length |-> !zl_rest)
  // Drop everything in flight on reset.
  `V3A_CHK_RST(a_rst_empty, !rst_n |=> !out_valid)

endmodule

bind vector3_alu v3a_chk u_v3a_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
